// File: rtl/first_fit_heap_allocator_macros.svh
// Assertion macros used by the checker file.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// A plain property, checked outside reset.
`define FFHA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ffha check failed");

// An implication from one condition to another, checked outside reset.
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    `FFHA_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// File: rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int unsigned HEADER_BYTES = 16;
    localparam logic [24:0] HEAP_LIMIT   = 25'd16777216;

    localparam logic [1:0] REG_HEAP_BASE  = 2'd0;
    localparam logic [1:0] REG_HEAP_BYTES = 2'd1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_BAD_REL = 2'd2;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [24:0] request_size;
        logic [31:0] release_address;
    } t_in;

    typedef struct packed {
        logic [31:0] block_address;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic [23:0] offset;
        logic [24:0] payload;
        logic        used;
    } t_seg;

    localparam int unsigned SEG_BITS = $bits(t_seg);

    // Datapath operations issued by the controller.
    localparam logic [4:0] OP_NOP         = 5'd0;
    localparam logic [4:0] OP_INIT        = 5'd1;
    localparam logic [4:0] OP_LOAD        = 5'd2;
    localparam logic [4:0] OP_RD_IDX      = 5'd3;
    localparam logic [4:0] OP_FIT         = 5'd4;
    localparam logic [4:0] OP_NEXT        = 5'd5;
    localparam logic [4:0] OP_FAIL        = 5'd6;
    localparam logic [4:0] OP_ALLOC_WHOLE = 5'd7;
    localparam logic [4:0] OP_SH_RD       = 5'd8;
    localparam logic [4:0] OP_SH_WR       = 5'd9;
    localparam logic [4:0] OP_SPLIT_HI    = 5'd10;
    localparam logic [4:0] OP_SPLIT_LO    = 5'd11;
    localparam logic [4:0] OP_REL_HIT     = 5'd12;
    localparam logic [4:0] OP_RD_PREV     = 5'd13;
    localparam logic [4:0] OP_MERGE_PREV  = 5'd14;
    localparam logic [4:0] OP_RD_SUCC     = 5'd15;
    localparam logic [4:0] OP_MERGE_SUCC  = 5'd16;
    localparam logic [4:0] OP_RM_RD       = 5'd17;
    localparam logic [4:0] OP_RM_WR       = 5'd18;
    localparam logic [4:0] OP_RM_END      = 5'd19;
    localparam logic [4:0] OP_REL_DONE    = 5'd20;

    typedef struct packed {
        logic [4:0] op;
    } t_cmd;

    typedef struct packed {
        logic in_func;
        logic idx_end;
        logic idx_zero;
        logic fit;
        logic split;
        logic match;
        logic rd_free;
        logic succ_avail;
        logic rm_more;
        logic k_above;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/ffha_ram.sv
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/ffha_ctrl.sv
module ffha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_reinit,
    input  ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_cmd  o_cmd
);
    localparam logic [4:0] S_INIT     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_A_RD     = 5'd2;
    localparam logic [4:0] S_A_CHK    = 5'd3;
    localparam logic [4:0] S_A_WHOLE  = 5'd4;
    localparam logic [4:0] S_SH_RD    = 5'd5;
    localparam logic [4:0] S_SH_WR    = 5'd6;
    localparam logic [4:0] S_SPL_LO   = 5'd7;
    localparam logic [4:0] S_FAIL     = 5'd8;
    localparam logic [4:0] S_R_RD     = 5'd9;
    localparam logic [4:0] S_R_CHK    = 5'd10;
    localparam logic [4:0] S_PRD      = 5'd11;
    localparam logic [4:0] S_PCHK     = 5'd12;
    localparam logic [4:0] S_SUCC_RD  = 5'd13;
    localparam logic [4:0] S_SCHK     = 5'd14;
    localparam logic [4:0] S_RM_RD    = 5'd15;
    localparam logic [4:0] S_RM_WR    = 5'd16;
    localparam logic [4:0] S_REL_DONE = 5'd17;

    logic [4:0] r_state, n_state;
    // Set while a removal belongs to the predecessor merge.
    logic       r_after_prev, n_after_prev;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_after_prev <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_after_prev <= n_after_prev;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_after_prev = r_after_prev;
        o_cmd.op     = ffha_pkg::OP_NOP;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = ffha_pkg::OP_INIT;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                if (i_reinit) begin
                    n_state = S_INIT;
                end else if (i_in_valid && o_in_ready) begin
                    o_cmd.op = ffha_pkg::OP_LOAD;
                    n_state  = S_A_RD;
                    if (i_stat.in_func == ffha_pkg::FUNC_RELEASE) begin
                        n_state = S_R_RD;
                    end
                end
            end
            S_A_RD: begin
                if (i_stat.idx_end) begin
                    n_state = S_FAIL;
                end else begin
                    o_cmd.op = ffha_pkg::OP_RD_IDX;
                    n_state  = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (i_stat.fit) begin
                    o_cmd.op = ffha_pkg::OP_FIT;
                    n_state  = i_stat.split ? S_SH_RD : S_A_WHOLE;
                end else begin
                    o_cmd.op = ffha_pkg::OP_NEXT;
                    n_state  = S_A_RD;
                end
            end
            S_A_WHOLE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = ffha_pkg::OP_ALLOC_WHOLE;
                    n_state  = S_IDLE;
                end
            end
            S_SH_RD: begin
                if (i_stat.k_above) begin
                    o_cmd.op = ffha_pkg::OP_SH_RD;
                    n_state  = S_SH_WR;
                end else begin
                    o_cmd.op = ffha_pkg::OP_SPLIT_HI;
                    n_state  = S_SPL_LO;
                end
            end
            S_SH_WR: begin
                o_cmd.op = ffha_pkg::OP_SH_WR;
                n_state  = S_SH_RD;
            end
            S_SPL_LO: begin
                if (i_stat.out_free) begin
                    o_cmd.op = ffha_pkg::OP_SPLIT_LO;
                    n_state  = S_IDLE;
                end
            end
            S_FAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.op = ffha_pkg::OP_FAIL;
                    n_state  = S_IDLE;
                end
            end
            S_R_RD: begin
                if (i_stat.idx_end) begin
                    n_state = S_FAIL;
                end else begin
                    o_cmd.op = ffha_pkg::OP_RD_IDX;
                    n_state  = S_R_CHK;
                end
            end
            S_R_CHK: begin
                if (i_stat.match) begin
                    o_cmd.op = ffha_pkg::OP_REL_HIT;
                    n_state  = i_stat.idx_zero ? S_SUCC_RD : S_PRD;
                end else begin
                    o_cmd.op = ffha_pkg::OP_NEXT;
                    n_state  = S_R_RD;
                end
            end
            S_PRD: begin
                o_cmd.op = ffha_pkg::OP_RD_PREV;
                n_state  = S_PCHK;
            end
            S_PCHK: begin
                if (i_stat.rd_free) begin
                    o_cmd.op     = ffha_pkg::OP_MERGE_PREV;
                    n_after_prev = 1'b1;
                    n_state      = S_RM_RD;
                end else begin
                    n_state = S_SUCC_RD;
                end
            end
            S_SUCC_RD: begin
                if (i_stat.succ_avail) begin
                    o_cmd.op = ffha_pkg::OP_RD_SUCC;
                    n_state  = S_SCHK;
                end else begin
                    n_state = S_REL_DONE;
                end
            end
            S_SCHK: begin
                if (i_stat.rd_free) begin
                    o_cmd.op     = ffha_pkg::OP_MERGE_SUCC;
                    n_after_prev = 1'b0;
                    n_state      = S_RM_RD;
                end else begin
                    n_state = S_REL_DONE;
                end
            end
            S_RM_RD: begin
                if (i_stat.rm_more) begin
                    o_cmd.op = ffha_pkg::OP_RM_RD;
                    n_state  = S_RM_WR;
                end else begin
                    o_cmd.op = ffha_pkg::OP_RM_END;
                    n_state  = r_after_prev ? S_SUCC_RD : S_REL_DONE;
                end
            end
            S_RM_WR: begin
                o_cmd.op = ffha_pkg::OP_RM_WR;
                n_state  = S_RM_RD;
            end
            S_REL_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = ffha_pkg::OP_REL_DONE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end
endmodule

// File: rtl/ffha_dp.sv
module ffha_dp #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffha_pkg::t_cmd  i_cmd,
    output ffha_pkg::t_stat o_stat,
    input  ffha_pkg::t_in   i_in,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ffha_pkg::t_out  o_out
);
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
    localparam logic [24:0] HDR25 = 25'(ffha_pkg::HEADER_BYTES);

    logic [31:0]    r_base;
    logic [24:0]    r_bytes;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_idx;
    logic [CW-1:0]  r_k;
    ffha_pkg::t_in  r_req;
    ffha_pkg::t_seg r_ent;
    logic           r_out_valid;
    ffha_pkg::t_out r_out;

    ffha_pkg::t_seg rd;
    logic [ffha_pkg::SEG_BITS-1:0] ram_rdata;
    logic           we;
    logic [IW-1:0]  waddr;
    logic [IW-1:0]  raddr;
    ffha_pkg::t_seg wdata;
    logic [24:0]    cfg_bytes;
    logic [25:0]    need;
    logic [31:0]    seg_addr;
    logic [31:0]    ent_addr;
    logic [25:0]    hi_off;
    logic [CW-1:0]  idx_p1;
    logic [CW-1:0]  idx_m1;
    logic [CW-1:0]  k_m1;
    logic [CW-1:0]  k_p1;
    logic           out_load;

    assign rd       = ffha_pkg::t_seg'(ram_rdata);
    assign idx_p1   = r_idx + CW'(1);
    assign idx_m1   = r_idx - CW'(1);
    assign k_m1     = r_k - CW'(1);
    assign k_p1     = r_k + CW'(1);
    assign need     = {1'b0, r_req.request_size} + 26'(ffha_pkg::HEADER_BYTES + 1);
    assign seg_addr = r_base + {8'd0, rd.offset} + 32'(ffha_pkg::HEADER_BYTES);
    assign ent_addr = r_base + {8'd0, r_ent.offset} + 32'(ffha_pkg::HEADER_BYTES);
    assign hi_off   = {2'b00, r_ent.offset} + 26'(ffha_pkg::HEADER_BYTES)
                    + {1'b0, r_req.request_size};
    assign cfg_bytes = (i_cfg_data[24:0] > ffha_pkg::HEAP_LIMIT) ?
                       ffha_pkg::HEAP_LIMIT : i_cfg_data[24:0];
    assign out_load = (i_cmd.op == ffha_pkg::OP_FAIL) ||
                      (i_cmd.op == ffha_pkg::OP_ALLOC_WHOLE) ||
                      (i_cmd.op == ffha_pkg::OP_SPLIT_LO) ||
                      (i_cmd.op == ffha_pkg::OP_REL_DONE);

    always_comb begin
        o_stat.in_func    = i_in.func;
        o_stat.idx_end    = (r_idx >= r_count);
        o_stat.idx_zero   = (r_idx == '0);
        o_stat.fit        = !rd.used && (rd.payload > r_req.request_size);
        o_stat.split      = ({1'b0, rd.payload} >= need) && (r_count < MAX_CNT);
        o_stat.match      = (seg_addr == r_req.release_address);
        o_stat.rd_free    = !rd.used;
        o_stat.succ_avail = (idx_p1 < r_count);
        o_stat.rm_more    = (k_p1 < r_count);
        o_stat.k_above    = (r_k > idx_p1);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // Table port selection.
    always_comb begin
        we    = 1'b0;
        waddr = r_idx[IW-1:0];
        wdata = r_ent;
        raddr = r_idx[IW-1:0];
        unique case (i_cmd.op)
            ffha_pkg::OP_INIT: begin
                we    = 1'b1;
                waddr = '0;
                wdata = '{offset: 24'd0, payload: r_bytes - HDR25, used: 1'b0};
            end
            ffha_pkg::OP_ALLOC_WHOLE: begin
                we         = 1'b1;
                wdata      = r_ent;
                wdata.used = 1'b1;
            end
            ffha_pkg::OP_SH_RD: raddr = k_m1[IW-1:0];
            ffha_pkg::OP_SH_WR: begin
                we    = 1'b1;
                waddr = r_k[IW-1:0];
                wdata = rd;
            end
            ffha_pkg::OP_SPLIT_HI: begin
                we    = 1'b1;
                waddr = idx_p1[IW-1:0];
                wdata = '{offset: hi_off[23:0],
                          payload: r_ent.payload - r_req.request_size - HDR25,
                          used: 1'b0};
            end
            ffha_pkg::OP_SPLIT_LO: begin
                we    = 1'b1;
                wdata = '{offset: r_ent.offset, payload: r_req.request_size, used: 1'b1};
            end
            ffha_pkg::OP_RD_PREV: raddr = idx_m1[IW-1:0];
            ffha_pkg::OP_RD_SUCC: raddr = idx_p1[IW-1:0];
            ffha_pkg::OP_RM_RD:   raddr = k_p1[IW-1:0];
            ffha_pkg::OP_RM_WR: begin
                we    = 1'b1;
                waddr = r_k[IW-1:0];
                wdata = rd;
            end
            ffha_pkg::OP_REL_DONE: begin
                we    = 1'b1;
                wdata = r_ent;
            end
            default: begin
            end
        endcase
    end

    ffha_ram #(
        .WIDTH (ffha_pkg::SEG_BITS),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_bytes     <= ffha_pkg::HEAP_LIMIT;
            r_count     <= '0;
            r_idx       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == ffha_pkg::REG_HEAP_BASE) begin
                r_base <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == ffha_pkg::REG_HEAP_BYTES) begin
                r_bytes <= cfg_bytes;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                ffha_pkg::OP_INIT: begin
                    r_count <= (r_bytes < HDR25) ? CW'(0) : CW'(1);
                end
                ffha_pkg::OP_LOAD:       r_idx <= '0;
                ffha_pkg::OP_NEXT:       r_idx <= idx_p1;
                ffha_pkg::OP_FIT:        r_k   <= r_count;
                ffha_pkg::OP_SPLIT_LO:   r_count <= r_count + CW'(1);
                ffha_pkg::OP_SH_WR:      r_k <= k_m1;
                ffha_pkg::OP_MERGE_PREV: begin
                    r_idx <= idx_m1;
                    r_k   <= r_idx;
                end
                ffha_pkg::OP_MERGE_SUCC: r_k <= idx_p1;
                ffha_pkg::OP_RM_WR:      r_k <= k_p1;
                ffha_pkg::OP_RM_END:     r_count <= r_count - CW'(1);
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            ffha_pkg::OP_LOAD: r_req <= i_in;
            ffha_pkg::OP_FIT:  r_ent <= rd;
            ffha_pkg::OP_REL_HIT: begin
                r_ent <= '{offset: rd.offset, payload: rd.payload, used: 1'b0};
            end
            ffha_pkg::OP_MERGE_PREV: begin
                r_ent <= '{offset: rd.offset,
                           payload: rd.payload + r_ent.payload + HDR25, used: 1'b0};
            end
            ffha_pkg::OP_MERGE_SUCC: begin
                r_ent.payload <= r_ent.payload + rd.payload + HDR25;
            end
            ffha_pkg::OP_FAIL: begin
                r_out.block_address <= '0;
                r_out.status <= (r_req.func == ffha_pkg::FUNC_RELEASE) ?
                                ffha_pkg::ST_BAD_REL : ffha_pkg::ST_NO_FIT;
            end
            ffha_pkg::OP_ALLOC_WHOLE, ffha_pkg::OP_SPLIT_LO: begin
                r_out.block_address <= ent_addr;
                r_out.status        <= ffha_pkg::ST_DONE;
            end
            ffha_pkg::OP_REL_DONE: begin
                r_out.block_address <= '0;
                r_out.status        <= ffha_pkg::ST_DONE;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

// File: rtl/first_fit_heap_allocator.sv
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_ready   i_in  (ffha_pkg::t_in)
// result    out        o_out_valid / i_out_ready o_out (ffha_pkg::t_out)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An item's time grows with each table entry scanned, and with each entry moved when a
// split opens a slot or a merge closes one; an allocate and a release add their own
// steps, and the table RAM with its registered read sets the pace.
// After reset, and after each heap_bytes write, the S_INIT state rebuilds the table.
// A waiting result holds in the output register; the next request is taken meanwhile
// and stalls only when its own result is ready while the earlier one still waits.
module first_fit_heap_allocator #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ffha_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ffha_pkg::t_out o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    ffha_pkg::t_cmd  cmd;
    ffha_pkg::t_stat stat;
    logic            cfg_we;

    assign cfg_we = i_cfg_valid && o_cfg_ready;

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_reinit    (cfg_we && i_cfg_index == ffha_pkg::REG_HEAP_BYTES),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ffha_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );
endmodule

// File: rtl/ffha_checker.sv
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input ffha_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input ffha_pkg::t_out o_out,
    input logic           i_cfg_valid,
    input logic           o_cfg_ready,
    input logic [1:0]     i_cfg_index,
    input logic [31:0]    i_cfg_data
);
    // A result that is not taken stays offered.
    `FFHA_ASSERT_IMP(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, ##1 o_out_valid)
    `FFHA_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_out_valid, o_out.status != 2'd3)
    // A failed request carries a zero address.
    `FFHA_ASSERT_IMP(a_fail_addr, i_clk, i_rst_n, o_out_valid && o_out.status != ffha_pkg::ST_DONE,
        o_out.block_address == 32'd0)
    // Requests are taken only when configuration could be taken too.
    `FFHA_ASSERT_IMP(a_in_idle, i_clk, i_rst_n, o_in_ready, o_cfg_ready && !i_cfg_valid)
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SEGS    = 64;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 600;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    ffha_pkg::t_in  i_in;
    logic           o_out_valid;
    logic           i_out_ready;
    ffha_pkg::t_out o_out;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index;
    logic [31:0]    i_cfg_data;

    first_fit_heap_allocator #(.MAX_SEGMENTS(MAX_SEGS)) DUT (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the segment table.
    logic [31:0] mdl_base;
    logic [24:0] mdl_bytes;
    logic [23:0] mdl_off [MAX_SEGS];
    logic [24:0] mdl_pay [MAX_SEGS];
    logic        mdl_used [MAX_SEGS];
    int          mdl_count;

    // Look-ahead copy of the table, advanced as requests are queued.
    logic [23:0] la_off [MAX_SEGS];
    logic [24:0] la_pay [MAX_SEGS];
    logic        la_used [MAX_SEGS];
    int          la_count;

    ffha_pkg::t_in  pending_reqs[$];
    ffha_pkg::t_out expected_results[$];
    int             errors = 0;
    bit             hold_req;
    bit             hold_done;
    int             hold_cnt;
    int             idle_cycles;

    // Predicted grant addresses, used to build releases; some stay listed after release.
    logic [31:0] live_addrs[$];

    function automatic logic [31:0] seg_addr(int idx);
        return mdl_base + 32'(mdl_off[idx]) + 32'(ffha_pkg::HEADER_BYTES);
    endfunction

    function automatic void table_rebuild();
        for (int k = 0; k < MAX_SEGS; k++) begin
            mdl_off[k] = '0;
            mdl_pay[k] = '0;
            mdl_used[k] = 1'b0;
        end
        if (mdl_bytes < ffha_pkg::HEADER_BYTES) begin
            mdl_count = 0;
        end else begin
            mdl_count = 1;
            mdl_pay[0] = mdl_bytes - 25'(ffha_pkg::HEADER_BYTES);
        end
    endfunction

    function automatic void drop_seg(int idx);
        for (int k = idx; k + 1 < mdl_count; k++) begin
            mdl_off[k] = mdl_off[k+1];
            mdl_pay[k] = mdl_pay[k+1];
            mdl_used[k] = mdl_used[k+1];
        end
        mdl_count--;
        mdl_off[mdl_count] = '0;
        mdl_pay[mdl_count] = '0;
        mdl_used[mdl_count] = 1'b0;
    endfunction

    function automatic ffha_pkg::t_out heap_op(ffha_pkg::t_in req);
        ffha_pkg::t_out r;
        int             i;
        r = '0;
        i = 0;
        if (req.func == ffha_pkg::FUNC_ALLOC) begin
            while (i < mdl_count && !(!mdl_used[i] && mdl_pay[i] > req.request_size)) i++;
            if (i == mdl_count) begin
                r.status = ffha_pkg::ST_NO_FIT;
                return r;
            end
            if (27'(mdl_pay[i]) >= 27'(req.request_size) + 27'(ffha_pkg::HEADER_BYTES) + 27'd1
                    && mdl_count < MAX_SEGS) begin
                for (int k = mdl_count; k > i + 1; k--) begin
                    mdl_off[k] = mdl_off[k-1];
                    mdl_pay[k] = mdl_pay[k-1];
                    mdl_used[k] = mdl_used[k-1];
                end
                mdl_off[i+1] = mdl_off[i] + 24'(ffha_pkg::HEADER_BYTES)
                             + 24'(req.request_size);
                mdl_pay[i+1] = mdl_pay[i] - req.request_size - 25'(ffha_pkg::HEADER_BYTES);
                mdl_used[i+1] = 1'b0;
                mdl_pay[i] = req.request_size;
                mdl_count++;
            end
            mdl_used[i] = 1'b1;
            r.block_address = seg_addr(i);
            r.status = ffha_pkg::ST_DONE;
            return r;
        end
        while (i < mdl_count && seg_addr(i) != req.release_address) i++;
        if (i == mdl_count) begin
            r.status = ffha_pkg::ST_BAD_REL;
            return r;
        end
        mdl_used[i] = 1'b0;
        if (i > 0 && !mdl_used[i-1]) begin
            mdl_pay[i-1] = mdl_pay[i-1] + mdl_pay[i] + 25'(ffha_pkg::HEADER_BYTES);
            drop_seg(i);
            i--;
        end
        if (i + 1 < mdl_count && !mdl_used[i+1]) begin
            mdl_pay[i] = mdl_pay[i] + mdl_pay[i+1] + 25'(ffha_pkg::HEADER_BYTES);
            drop_seg(i + 1);
        end
        r.status = ffha_pkg::ST_DONE;
        return r;
    endfunction

    function automatic void la_sync();
        la_off = mdl_off;
        la_pay = mdl_pay;
        la_used = mdl_used;
        la_count = mdl_count;
    endfunction

    // Run the predictor on the look-ahead copy by swapping it in.
    function automatic ffha_pkg::t_out la_run(ffha_pkg::t_in t);
        logic [23:0]    s_off [MAX_SEGS];
        logic [24:0]    s_pay [MAX_SEGS];
        logic           s_used [MAX_SEGS];
        int             s_count;
        ffha_pkg::t_out r;
        s_off = mdl_off;
        s_pay = mdl_pay;
        s_used = mdl_used;
        s_count = mdl_count;
        mdl_off = la_off;
        mdl_pay = la_pay;
        mdl_used = la_used;
        mdl_count = la_count;
        r = heap_op(t);
        la_off = mdl_off;
        la_pay = mdl_pay;
        la_used = mdl_used;
        la_count = mdl_count;
        mdl_off = s_off;
        mdl_pay = s_pay;
        mdl_used = s_used;
        mdl_count = s_count;
        return r;
    endfunction

    function automatic ffha_pkg::t_out predict_grant(ffha_pkg::t_in t);
        return la_run(t);
    endfunction

    function automatic void sim_shadow(ffha_pkg::t_in t);
        if (t.func == ffha_pkg::FUNC_RELEASE) void'(la_run(t));
    endfunction

    // Expected results are predicted at each accepted request.
    bit sent_flag;
    always @(posedge i_clk) begin
        sent_flag <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_results.push_back(heap_op(i_in));
        end
    end

    // Driver: bursts with random gaps.
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!i_in_valid || sent_flag) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_in <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off counted here.
    int stall_phase;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_phase <= 0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                hold_cnt <= hold_cnt + 1;
                if (hold_cnt >= HOLD_CYCLES - 1)
                    hold_done <= 1'b1;
            end else if (stall_phase[9:7] == 3'd0)
                i_out_ready <= 1'b1;
            else
                i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        ffha_pkg::t_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result addr=%h status=%0d",
                         $time, o_out.block_address, o_out.status);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out.block_address !== exp_r.block_address) begin
                    $display("%0t: block_address expected %h actual %h",
                             $time, exp_r.block_address, o_out.block_address);
                    errors++;
                end
                if (o_out.status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, o_out.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on accepted transactions of any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready) || (hold_req && !hold_done)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        // Let the last table write-back finish before configuration changes.
        repeat (4 * MAX_SEGS + 16) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == ffha_pkg::REG_HEAP_BASE) begin
            mdl_base = val;
        end else begin
            mdl_bytes = (val[24:0] > ffha_pkg::HEAP_LIMIT) ? ffha_pkg::HEAP_LIMIT : val[24:0];
            table_rebuild();
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic ffha_pkg::t_in mk_alloc(logic [24:0] sz);
        ffha_pkg::t_in t;
        t = '0;
        t.func = ffha_pkg::FUNC_ALLOC;
        t.request_size = sz;
        t.release_address = 32'($urandom);
        return t;
    endfunction

    function automatic ffha_pkg::t_in mk_rel(logic [31:0] a);
        ffha_pkg::t_in t;
        t = '0;
        t.func = ffha_pkg::FUNC_RELEASE;
        t.request_size = 25'($urandom);
        t.release_address = a;
        return t;
    endfunction

    // Random phase. Most releases pick candidates from a running list of past grants.
    task automatic random_phase(int n, int max_sz);
        ffha_pkg::t_in  t;
        ffha_pkg::t_out g;
        int             pick;
        for (int j = 0; j < n; j++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    t = mk_alloc(($urandom_range(0, 15) == 0) ? 25'($urandom)
                                                              : 25'($urandom_range(0, max_sz)));
                end
                5, 6, 7, 8: begin
                    if (live_addrs.size() > 0) begin
                        pick = $urandom_range(0, live_addrs.size() - 1);
                        t = mk_rel(live_addrs[pick]);
                        if ($urandom_range(0, 5) != 0) live_addrs.delete(pick);
                    end else begin
                        t = mk_rel(32'($urandom));
                    end
                end
                default: t = mk_rel(($urandom_range(0, 1) == 0) ? 32'($urandom)
                                    : mdl_base + 32'($urandom_range(0, 4096)));
            endcase
            // Predict the grant address ahead so releases can target it later;
            // a scratch copy keeps the real shadow untouched.
            if (t.func == ffha_pkg::FUNC_ALLOC) begin
                g = predict_grant(t);
                if (g.status == ffha_pkg::ST_DONE) live_addrs.push_back(g.block_address);
            end
            pending_reqs.push_back(t);
            sim_shadow(t);
        end
    endtask

    task automatic directed_phase();
        ffha_pkg::t_in  t;
        ffha_pkg::t_out g;
        logic [24:0]    sizes[9];
        sizes = '{25'd0, 25'd1, 25'd15, 25'd16, 25'd17, 25'd100,
                  25'h1FFFFFF, 25'd16777216, 25'd16777199};
        la_sync();
        foreach (sizes[k]) begin
            t = mk_alloc(sizes[k]);
            g = predict_grant(t);
            if (g.status == ffha_pkg::ST_DONE) live_addrs.push_back(g.block_address);
            pending_reqs.push_back(t);
        end
        // Unknown addresses, then release in reverse order of the grants.
        pending_reqs.push_back(mk_rel(32'hFFFFFFFF));
        pending_reqs.push_back(mk_rel(32'h0));
        void'(la_run(mk_rel(32'hFFFFFFFF)));
        void'(la_run(mk_rel(32'h0)));
        while (live_addrs.size() > 0) begin
            t = mk_rel(live_addrs.pop_back());
            pending_reqs.push_back(t);
            void'(la_run(t));
            // Releasing an already free segment is legal too.
            if (live_addrs.size() == 2) begin
                pending_reqs.push_back(t);
                void'(la_run(t));
            end
        end
    endtask

    task automatic fill_table();
        ffha_pkg::t_in  t;
        ffha_pkg::t_out g;
        la_sync();
        for (int k = 0; k < MAX_SEGS + 4; k++) begin
            t = mk_alloc(25'($urandom_range(0, 40)));
            g = predict_grant(t);
            if (g.status == ffha_pkg::ST_DONE) live_addrs.push_back(g.block_address);
            pending_reqs.push_back(t);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ffha_pkg::REG_HEAP_BASE;
        i_cfg_data = '0;
        hold_req = 1'b0;
        mdl_base = '0;
        mdl_bytes = ffha_pkg::HEAP_LIMIT;
        table_rebuild();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_phase();
        wait_drained();

        cfg_write(ffha_pkg::REG_HEAP_BYTES, 32'd10);
        live_addrs.delete();
        la_sync();
        pending_reqs.push_back(mk_alloc(25'd0));
        void'(la_run(mk_alloc(25'd0)));
        wait_drained();

        cfg_write(ffha_pkg::REG_HEAP_BASE, 32'hFFFFFFF0);
        cfg_write(ffha_pkg::REG_HEAP_BYTES, 32'hFFFFFFFF);
        live_addrs.delete();
        fill_table();
        // Long receiver hold-off while the sender keeps offering.
        hold_req = 1'b1;
        wait (hold_done);
        wait_drained();

        cfg_write(ffha_pkg::REG_HEAP_BASE, 32'h0001_0000);
        cfg_write(ffha_pkg::REG_HEAP_BYTES, 32'd4096);
        live_addrs.delete();
        la_sync();
        random_phase(600, 200);
        wait_drained();

        cfg_write(ffha_pkg::REG_HEAP_BASE, 32'($urandom));
        cfg_write(ffha_pkg::REG_HEAP_BYTES, 32'd16);
        live_addrs.delete();
        la_sync();
        random_phase(50, 4);
        wait_drained();

        cfg_write(ffha_pkg::REG_HEAP_BYTES, 32'd1500);
        live_addrs.delete();
        la_sync();
        random_phase(600, 60);
        wait_drained();

        cfg_write(ffha_pkg::REG_HEAP_BASE, 32'h0);
        cfg_write(ffha_pkg::REG_HEAP_BYTES, 32'd16777216);
        live_addrs.delete();
        la_sync();
        random_phase(550, 400000);
        wait_drained();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_ctrl.sv
rtl/ffha_dp.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
tb/tb.sv
